// ----- sv/mlp_pkg.sv -----
// ----------------------------------------------------------------------------
// mlp_pkg: shared types and constants for the perceptron classifier.
// Word layouts, default sizes and the exponential table generator.
// ----------------------------------------------------------------------------
package mlp_pkg;

  localparam int unsigned InSize        = 64;
  localparam int unsigned HiddenOne     = 32;
  localparam int unsigned HiddenTwo     = 16;
  localparam int unsigned Classes       = 3;
  localparam int unsigned ExpTableDepth = 256;

  localparam logic [16:0] InvTempReset = 17'd4096;
  localparam logic [63:0] ExpRatio     = 64'd4034748382;

  localparam logic [1:0] InvTempAddr = 2'd0;

  localparam logic CmdParam   = 1'b0;
  localparam logic CmdFeature = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [11:0]       address;
    logic signed [15:0] value;
    logic              final_feature;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  class_index;
    logic [15:0] probability;
    logic        last;
    logic        invalid;
  } out_word_t;

  // Entry i of the table: 2^32 scaled by exp(-i/16), rounded at each step.
  function automatic logic [32:0] exp_entry(input int unsigned idx);
    logic [32:0] e;
    logic [95:0] p;
    e = 33'h1_0000_0000;
    for (int unsigned i = 0; i < idx; i++) begin
      p = 96'(e) * 96'(ExpRatio) + 96'h8000_0000;
      e = p[64:32];
    end
    return e;
  endfunction

endpackage

// ----- sv/mlp_divider.sv -----
// ----------------------------------------------------------------------------
// mlp_divider: restoring divider, one quotient bit per cycle.
// Divides a 49-bit numerator by a 37-bit denominator.
// ----------------------------------------------------------------------------
module mlp_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [48:0] num_i,
  input  logic [36:0] den_i,
  output logic        done_o,
  output logic [48:0] quot_o
);

  logic [48:0] quot_q, quot_d;
  logic [37:0] rem_q, rem_d;
  logic [36:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [37:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[36:0], quot_q[48]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 6'd49;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[47:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[47:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = busy_q && (cnt_q == 6'd1);
  assign quot_o = quot_d;

endmodule

// ----- sv/mlp_relu_softmax_classifier.sv -----
// ----------------------------------------------------------------------------
// mlp_relu_softmax_classifier: three-layer perceptron with softmax output.
// Loads parameters and features, then runs all layers on one shared MAC.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake               | Word
// in      | input     | in_valid_i/in_stall_o   | mlp_pkg::in_word_t
// out     | output    | out_valid_o/out_stall_i | mlp_pkg::out_word_t
// cfg     | input     | APB                     | inv_temperature at 0
// A load word is taken whenever the input is not stalled, so load words can follow back to back.
// An inference steps each multiply-accumulate through memory read, multiply and
// accumulate, each bias through read and accumulate, and each class through the
// divide and the output word.
// Reset is asynchronous; the stores are undefined until written.
// The input is stalled while an inference runs and while a result waits under
// out_stall_i; a result waits in the output register while out_stall_i is high.
module mlp_relu_softmax_classifier #(
  parameter int unsigned IN_SIZE         = mlp_pkg::InSize,
  parameter int unsigned HIDDEN_ONE      = mlp_pkg::HiddenOne,
  parameter int unsigned HIDDEN_TWO      = mlp_pkg::HiddenTwo,
  parameter int unsigned CLASSES         = mlp_pkg::Classes,
  parameter int unsigned EXP_TABLE_DEPTH = mlp_pkg::ExpTableDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mlp_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mlp_pkg::out_word_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned OffB1 = IN_SIZE * HIDDEN_ONE;
  localparam int unsigned OffW2 = OffB1 + HIDDEN_ONE;
  localparam int unsigned OffB2 = OffW2 + HIDDEN_ONE * HIDDEN_TWO;
  localparam int unsigned OffW3 = OffB2 + HIDDEN_TWO;
  localparam int unsigned OffB3 = OffW3 + HIDDEN_TWO * CLASSES;
  localparam int unsigned ParamDepth = OffB3 + CLASSES;
  localparam int unsigned PW = $clog2(ParamDepth);
  localparam int unsigned FW = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
  localparam int unsigned H1W = (HIDDEN_ONE > 1) ? $clog2(HIDDEN_ONE) : 1;
  localparam int unsigned H2W = (HIDDEN_TWO > 1) ? $clog2(HIDDEN_TWO) : 1;
  localparam int unsigned CW = $clog2(CLASSES);
  localparam int unsigned IW = 11;
  localparam int unsigned EW = $clog2(EXP_TABLE_DEPTH);

  typedef enum logic [9:0] {
    StIdle     = 10'b0000000001,
    StRead     = 10'b0000000010,
    StMul      = 10'b0000000100,
    StAcc      = 10'b0000001000,
    StScale    = 10'b0000010000,
    StMax      = 10'b0000100000,
    StExp      = 10'b0001000000,
    StDivStart = 10'b0010000000,
    StDiv      = 10'b0100000000,
    StOut      = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] param_mem [ParamDepth];
  logic [15:0] feat_mem  [IN_SIZE];
  logic [31:0] act1_mem  [HIDDEN_ONE];
  logic [31:0] act2_mem  [HIDDEN_TWO];
  logic signed [31:0] logit_q [CLASSES];
  logic [32:0] num_q [CLASSES];
  logic [32:0] exp_tab [EXP_TABLE_DEPTH];

  logic [16:0] inv_temp_q;
  logic        bad_q;
  logic [1:0]  layer_q, layer_d;
  logic        bias_q, bias_d;
  logic [IW-1:0] i_q, i_d, o_q, o_d;
  logic signed [31:0] acc_q;
  logic signed [63:0] prod_q;
  logic [15:0] prd_q;
  logic [31:0] ard_q;
  logic signed [31:0] mx_q;
  logic [36:0] den_q;
  logic        out_valid_q;
  mlp_pkg::out_word_t out_q;

  logic        in_acc;
  logic        cfg_wr;
  logic        bad_final;
  logic        out_fire;
  logic [PW-1:0] p_addr;
  logic signed [63:0] shifted, sum;
  logic signed [31:0] sat;
  logic [IW-1:0] n_in, n_out;
  logic [32:0] diff;
  logic [33:0] idx;
  logic [32:0] exp_val;
  logic        div_start, div_done;
  logic [48:0] quot;

  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_exp_tab
    assign exp_tab[g] = mlp_pkg::exp_entry(g);
  end

  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == mlp_pkg::InvTempAddr);
  assign pready = 1'b1;
  assign prdata = (paddr == mlp_pkg::InvTempAddr) ? {15'd0, inv_temp_q} : 32'd0;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
  assign bad_final = in_acc && in_data_i.cmd == mlp_pkg::CmdFeature &&
                     in_data_i.final_feature &&
                     (bad_q || (32'(in_data_i.address) < IN_SIZE && in_data_i.value < 0));
  assign out_fire = (state_q == StOut) && (!out_valid_q || !out_stall_i);

  always_comb begin
    n_in  = (layer_q == 2'd0) ? IW'(IN_SIZE) : (layer_q == 2'd1) ? IW'(HIDDEN_ONE)
                                                                  : IW'(HIDDEN_TWO);
    n_out = (layer_q == 2'd0) ? IW'(HIDDEN_ONE) : (layer_q == 2'd1) ? IW'(HIDDEN_TWO)
                                                                   : IW'(CLASSES);
    if (bias_q) begin
      p_addr = (layer_q == 2'd0) ? PW'(OffB1 + 32'(o_q))
             : (layer_q == 2'd1) ? PW'(OffB2 + 32'(o_q)) : PW'(OffB3 + 32'(o_q));
    end else begin
      p_addr = (layer_q == 2'd0) ? PW'(32'(i_q) * HIDDEN_ONE + 32'(o_q))
             : (layer_q == 2'd1) ? PW'(OffW2 + 32'(i_q) * HIDDEN_TWO + 32'(o_q))
                                 : PW'(OffW3 + 32'(i_q) * CLASSES + 32'(o_q));
    end
    shifted = (layer_q == 2'd0) ? (prod_q >>> 15) : (prod_q >>> 12);
    if (state_q == StScale) shifted = prod_q >>> 12;
    sum = (state_q == StScale) ? shifted : 64'(acc_q) + shifted;
    if (sum > 64'sd2147483647) sat = 32'sh7fffffff;
    else if (sum < -64'sd2147483648) sat = 32'sh80000000;
    else sat = sum[31:0];
    diff = 33'(mx_q) - 33'(logit_q[CW'(o_q)]);
    idx  = 34'(diff) + 34'd128;
    exp_val = (idx[33:8] < 26'(EXP_TABLE_DEPTH)) ? exp_tab[EW'(idx[33:8])] : '0;
  end

  mlp_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({num_q[CW'(o_q)], 16'd0} + 49'(den_q >> 1)),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    state_d = state_q;
    layer_d = layer_q;
    bias_d  = bias_q;
    i_d     = i_q;
    o_d     = o_q;
    div_start = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_acc && in_data_i.cmd == mlp_pkg::CmdFeature && in_data_i.final_feature &&
            !(bad_q || (32'(in_data_i.address) < IN_SIZE && in_data_i.value < 0))) begin
          state_d = StRead;
          layer_d = 2'd0;
          bias_d  = 1'b1;
          i_d = '0;
          o_d = '0;
        end
      end
      StRead: state_d = bias_q ? StAcc : StMul;
      StMul:  state_d = StAcc;
      StAcc: begin
        state_d = StRead;
        if (bias_q) begin
          bias_d = 1'b0;
        end else if (i_q == n_in - 1) begin
          i_d = '0;
          bias_d = 1'b1;
          if (layer_q == 2'd2) begin
            state_d = StScale;
          end else if (o_q == n_out - 1) begin
            o_d = '0;
            layer_d = layer_q + 2'd1;
          end else begin
            o_d = o_q + 1'b1;
          end
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      StScale: begin
        if (o_q == n_out - 1) begin
          o_d = '0;
          state_d = StMax;
        end else begin
          o_d = o_q + 1'b1;
          state_d = StRead;
        end
      end
      StMax: begin
        if (o_q == IW'(CLASSES - 1)) begin
          o_d = '0;
          state_d = StExp;
        end else o_d = o_q + 1'b1;
      end
      StExp: begin
        if (o_q == IW'(CLASSES - 1)) begin
          o_d = '0;
          state_d = StDivStart;
        end else o_d = o_q + 1'b1;
      end
      StDivStart: begin
        div_start = 1'b1;
        state_d = StDiv;
      end
      StDiv: if (div_done) state_d = StOut;
      StOut: begin
        if (!out_valid_q || !out_stall_i) begin
          if (o_q == IW'(CLASSES - 1)) state_d = StIdle;
          else begin
            o_d = o_q + 1'b1;
            state_d = StDivStart;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.cmd == mlp_pkg::CmdParam && 32'(in_data_i.address) < ParamDepth)
      param_mem[PW'(in_data_i.address)] <= in_data_i.value;
    if (in_acc && in_data_i.cmd == mlp_pkg::CmdFeature && 32'(in_data_i.address) < IN_SIZE)
      feat_mem[FW'(in_data_i.address)] <= in_data_i.value;
    if (state_q == StRead) begin
      prd_q <= param_mem[p_addr];
      ard_q <= (layer_q == 2'd0) ? 32'(signed'(feat_mem[FW'(i_q)]))
             : (layer_q == 2'd1) ? act1_mem[H1W'(i_q)] : act2_mem[H2W'(i_q)];
    end
    if (state_q == StMul) prod_q <= 64'(signed'(ard_q)) * 64'(signed'(prd_q));
    if (state_q == StAcc) begin
      if (bias_q) acc_q <= 32'(signed'(prd_q));
      else begin
        acc_q <= sat;
        if (i_q == n_in - 1) begin
          if (layer_q == 2'd0) act1_mem[H1W'(o_q)] <= sat[31] ? 32'd0 : sat;
          if (layer_q == 2'd1) act2_mem[H2W'(o_q)] <= sat[31] ? 32'd0 : sat;
          if (layer_q == 2'd2) prod_q <= 64'(sat) * 64'(signed'({1'b0, inv_temp_q}));
        end
      end
    end
    if (state_q == StScale) logit_q[CW'(o_q)] <= sat;
    if (state_q == StMax) begin
      if (o_q == '0 || logit_q[CW'(o_q)] > mx_q) mx_q <= logit_q[CW'(o_q)];
    end
    if (state_q == StExp) begin
      num_q[CW'(o_q)] <= exp_val;
      den_q <= ((o_q == '0) ? 37'd0 : den_q) + 37'(exp_val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      layer_q     <= '0;
      bias_q      <= 1'b0;
      i_q         <= '0;
      o_q         <= '0;
      inv_temp_q  <= mlp_pkg::InvTempReset;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;
      layer_q <= layer_d;
      bias_q  <= bias_d;
      i_q     <= i_d;
      o_q     <= o_d;
      if (cfg_wr) inv_temp_q <= pwdata[16:0];
      if (bad_final || out_fire) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (in_acc && in_data_i.cmd == mlp_pkg::CmdFeature) begin
        if (in_data_i.final_feature) begin
          bad_q <= 1'b0;
          if (bad_final) begin
            out_q <= '{class_index: 4'd0, probability: 16'd0, last: 1'b1, invalid: 1'b1};
          end
        end else if (32'(in_data_i.address) < IN_SIZE && in_data_i.value < 0) begin
          bad_q <= 1'b1;
        end
      end
      if (out_fire) begin
        out_q.class_index <= 4'(o_q);
        out_q.probability <= (quot > 49'd65535) ? 16'hffff : quot[15:0];
        out_q.last        <= (o_q == IW'(CLASSES - 1));
        out_q.invalid     <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q) else $error("result dropped");
  a_out_onlast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.invalid) |-> out_q.last) else $error("invalid not last");
`endif

endmodule

// ----- dv/mlp_relu_softmax_classifier_checker.sv -----
// ----------------------------------------------------------------------------
// mlp_relu_softmax_classifier_checker: predictor and scoreboard.
// Watches the input, output and register channels, computes the class
// probabilities that each accepted final feature word should give and compares
// them with the words leaving the block, all fields in one check.
// ----------------------------------------------------------------------------
module mlp_relu_softmax_classifier_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  mlp_pkg::in_word_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  mlp_pkg::out_word_t out_data_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 failures_o,
  output int                 pending_o
);

  localparam int unsigned InSize        = mlp_pkg::InSize;
  localparam int unsigned HiddenOne     = mlp_pkg::HiddenOne;
  localparam int unsigned HiddenTwo     = mlp_pkg::HiddenTwo;
  localparam int unsigned Classes       = mlp_pkg::Classes;
  localparam int unsigned ExpTableDepth = mlp_pkg::ExpTableDepth;
  localparam int unsigned OffB1 = InSize * HiddenOne;
  localparam int unsigned OffW2 = OffB1 + HiddenOne;
  localparam int unsigned OffB2 = OffW2 + HiddenOne * HiddenTwo;
  localparam int unsigned OffW3 = OffB2 + HiddenTwo;
  localparam int unsigned OffB3 = OffW3 + HiddenTwo * Classes;
  localparam int unsigned ParamDepth = OffB3 + Classes;

  logic signed [15:0] weights [ParamDepth];
  logic signed [15:0] features [InSize];
  int                 act_one [HiddenOne];
  int                 act_two [HiddenTwo];
  logic               vector_bad;
  logic [16:0]        inv_temp;
  longint unsigned    exp_lut [ExpTableDepth];
  mlp_pkg::out_word_t expected_probs [$];
  int                 failures;

  assign failures_o = failures;
  assign pending_o  = expected_probs.size();

  initial begin
    logic [95:0] prod;
    failures = 0;
    exp_lut[0] = 64'h1_0000_0000;
    for (int i = 1; i < ExpTableDepth; i++) begin
      prod = 96'(exp_lut[i-1]) * 96'(mlp_pkg::ExpRatio) + (96'd1 << 31);
      exp_lut[i] = prod[95:32];
    end
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic classify(input mlp_pkg::in_word_t w);
    longint acc;
    longint logit [Classes];
    longint top_logit;
    longint idx;
    longint unsigned num [Classes];
    longint unsigned den;
    longint unsigned p;
    mlp_pkg::out_word_t r;
    if (w.cmd == mlp_pkg::CmdParam) begin
      if (w.address < ParamDepth) weights[w.address] = w.value;
      return;
    end
    if (w.address < InSize) begin
      features[w.address] = w.value;
      if (w.value < 0) vector_bad = 1'b1;
    end
    if (!w.final_feature) return;
    if (vector_bad) begin
      vector_bad = 1'b0;
      r = '{class_index: 4'd0, probability: 16'd0, last: 1'b1, invalid: 1'b1};
      expected_probs.insert(expected_probs.size(), r);
      return;
    end
    for (int o = 0; o < HiddenOne; o++) begin
      acc = longint'(weights[OffB1 + o]);
      for (int i = 0; i < InSize; i++)
        acc = clamp32(acc + ((longint'(features[i]) *
                              longint'(weights[i * HiddenOne + o])) >>> 15));
      act_one[o] = (acc < 0) ? 0 : int'(acc);
    end
    for (int o = 0; o < HiddenTwo; o++) begin
      acc = longint'(weights[OffB2 + o]);
      for (int i = 0; i < HiddenOne; i++)
        acc = clamp32(acc + ((longint'(act_one[i]) *
                              longint'(weights[OffW2 + i * HiddenTwo + o])) >>> 12));
      act_two[o] = (acc < 0) ? 0 : int'(acc);
    end
    for (int o = 0; o < Classes; o++) begin
      acc = longint'(weights[OffB3 + o]);
      for (int i = 0; i < HiddenTwo; i++)
        acc = clamp32(acc + ((longint'(act_two[i]) *
                              longint'(weights[OffW3 + i * Classes + o])) >>> 12));
      logit[o] = clamp32((acc * longint'(inv_temp)) >>> 12);
    end
    top_logit = logit[0];
    for (int k = 1; k < Classes; k++)
      if (logit[k] > top_logit) top_logit = logit[k];
    den = 0;
    for (int k = 0; k < Classes; k++) begin
      idx = ((top_logit - logit[k]) + 128) >>> 8;
      num[k] = (idx < ExpTableDepth) ? exp_lut[idx] : 64'd0;
      den += num[k];
    end
    for (int k = 0; k < Classes; k++) begin
      p = ((num[k] << 16) + den / 2) / den;
      if (p > 65535) p = 65535;
      r.class_index = 4'(k);
      r.probability = 16'(p);
      r.last        = (k == Classes - 1);
      r.invalid     = 1'b0;
      expected_probs.insert(expected_probs.size(), r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mlp_pkg::out_word_t exp_w;
    if (!rst_ni) begin
      vector_bad = 1'b0;
      inv_temp   = mlp_pkg::InvTempReset;
    end else begin
      if (psel && penable && pwrite && pready && paddr == mlp_pkg::InvTempAddr)
        inv_temp = pwdata[16:0];
      if (in_valid_i && !in_stall_i) classify(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_probs.size() == 0) begin
          failures++;
          $display("%0t: unexpected word %p", $time, out_data_i);
        end else begin
          exp_w = expected_probs.pop_front();
          if (exp_w.class_index !== out_data_i.class_index ||
              exp_w.probability !== out_data_i.probability ||
              exp_w.last !== out_data_i.last || exp_w.invalid !== out_data_i.invalid) begin
            failures++;
            $display("%0t: mismatch, expected %p, got %p", $time, exp_w, out_data_i);
          end
        end
      end
    end
  end

endmodule

// ----- dv/mlp_relu_softmax_classifier_test.sv -----
// ----------------------------------------------------------------------------
// mlp_relu_softmax_classifier_test: top-level testbench.
// Loads a full parameter set and feature vector, runs directed corner cases,
// then random feature sequences and parameter rewrites under several idling
// patterns and temperature settings, with a checker judging every result.
// ----------------------------------------------------------------------------
module mlp_relu_softmax_classifier_test;

  localparam int unsigned InSize     = mlp_pkg::InSize;
  localparam int unsigned HiddenOne  = mlp_pkg::HiddenOne;
  localparam int unsigned HiddenTwo  = mlp_pkg::HiddenTwo;
  localparam int unsigned Classes    = mlp_pkg::Classes;
  localparam int unsigned ParamDepth =
    InSize * HiddenOne + HiddenOne + HiddenOne * HiddenTwo + HiddenTwo +
    HiddenTwo * Classes + Classes;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  mlp_pkg::in_word_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  mlp_pkg::out_word_t out_data_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [1:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 failures;
  int                 pending;
  int                 send_idle;
  int                 recv_stall;

  mlp_relu_softmax_classifier uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  mlp_relu_softmax_classifier_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .failures_o(failures), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall);
  end

  task automatic send(input logic cmd, input logic [11:0] addr,
                      input logic [15:0] val, input logic fin);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = '{cmd: cmd, address: addr, value: val, final_feature: fin};
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_weight();
    if ($urandom_range(15) == 0) return 16'($urandom);
    return 16'($urandom_range(2047) - 1024);
  endfunction

  task automatic drain(input int settle);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic set_inv_temp(input logic [16:0] v);
    drain(100);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = mlp_pkg::InvTempAddr;
    pwdata = 32'(v);
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic random_phase(input int budget);
    int n;
    int k;
    int r;
    n = 0;
    while (n < budget) begin
      r = $urandom_range(99);
      if (r < 70) begin
        k = $urandom_range(6, 1);
        for (int j = 0; j < k; j++)
          send(mlp_pkg::CmdFeature, 12'($urandom_range(InSize - 1)),
               ($urandom_range(19) == 0) ? 16'($urandom_range(65535, 32768))
                                         : 16'($urandom_range(32767)),
               j == k - 1);
        n += k;
      end else if (r < 85) begin
        send(mlp_pkg::CmdParam, 12'($urandom_range(ParamDepth - 1)), rand_weight(),
             1'($urandom));
        n++;
      end else if (r < 93) begin
        send(mlp_pkg::CmdFeature, 12'($urandom_range(4095, InSize)), 16'($urandom),
             1'($urandom));
        n++;
      end else begin
        send(mlp_pkg::CmdParam, 12'($urandom_range(4095, ParamDepth)), 16'($urandom),
             1'($urandom));
        n++;
      end
    end
  endtask

  initial begin
    in_valid_i = 1'b0; in_data_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    send_idle = 0; recv_stall = 0;
    rst_ni = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int a = 0; a < ParamDepth; a++)
      send(mlp_pkg::CmdParam, 12'(a), rand_weight(), 1'b0);
    for (int a = 0; a < InSize; a++)
      send(mlp_pkg::CmdFeature, 12'(a), 16'($urandom_range(32767)), 1'b0);

    send(mlp_pkg::CmdFeature, 12'(InSize - 1), 16'd32767, 1'b1);
    send(mlp_pkg::CmdFeature, 12'd0, 16'd0, 1'b1);
    send(mlp_pkg::CmdFeature, 12'd5, 16'h8000, 1'b0);
    send(mlp_pkg::CmdFeature, 12'd5, 16'd100, 1'b1);
    send(mlp_pkg::CmdFeature, 12'd4095, 16'hffff, 1'b1);
    send(mlp_pkg::CmdParam, 12'd4095, 16'h7fff, 1'b1);
    send(mlp_pkg::CmdParam, 12'(ParamDepth - 1), 16'h7fff, 1'b1);
    send(mlp_pkg::CmdParam, 12'(ParamDepth - 2), 16'h8000, 1'b0);
    send(mlp_pkg::CmdFeature, 12'(InSize), 16'd5, 1'b0);
    send(mlp_pkg::CmdFeature, 12'd7, 16'hffff, 1'b1);
    send(mlp_pkg::CmdFeature, 12'd7, 16'd1, 1'b1);

    set_inv_temp(17'd410);
    send_idle = 0; recv_stall = 0;
    random_phase(70);
    set_inv_temp(17'd81920);
    send_idle = 88; recv_stall = 0;
    random_phase(70);
    set_inv_temp(17'd0);
    send(mlp_pkg::CmdFeature, 12'd1, 16'd200, 1'b1);
    set_inv_temp(17'h1ffff);
    send_idle = 0; recv_stall = 88;
    random_phase(70);
    set_inv_temp(17'($urandom_range(81920, 410)));
    send_idle = 11; recv_stall = 11;
    random_phase(70);

    drain(200);
    if (failures == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
